/* rtl/rhsv_pkg.sv */
// Shared types and constants for the 8-bit RGB to HSV converter.
// No dependencies; used by rhsv_divstage and rgb_to_hsv_8bit.
package rhsv_pkg;

   localparam int CHAN_W = 8;    // pixel channel and result width
   localparam int NUM_W  = 11;   // hue numerator, 0 .. 6*delta-1 <= 1529
   localparam int REM_W  = 20;   // dividend / partial remainder
   localparam int DEN_W  = 12;   // divisor, up to 12*255
   localparam int Q_W    = 8;    // quotient bits, results never exceed 255

   // 2*255, numerator scale shared by the hue and saturation quotients
   localparam logic [9:0] SCALE2 = 10'd510;

   typedef enum logic [1:0] {
      SECT_RED   = 2'd0,
      SECT_GREEN = 2'd1,
      SECT_BLUE  = 2'd2
   } sect_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [DEN_W-1:0] den;
      logic [Q_W-1:0]   quo;
   } div_type;

endpackage

/* rtl/rhsv_divstage.sv */
// One registered step of the restoring divider: resolves two quotient bits.
// Depends on rhsv_pkg for div_type and the field widths.
module rhsv_divstage
   import rhsv_pkg::*;
(
   input  logic       clock,
   input  logic       advance,
   input  logic [2:0] hi_bit,
   input  div_type    d_in,
   output div_type    d_out_ff
);

   div_type          d_out_in;
   logic [2:0]       lo_bit;
   logic [REM_W-1:0] sub_hi;
   logic [REM_W-1:0] sub_lo;
   logic [REM_W-1:0] rem_mid;
   logic             ge_hi;
   logic             ge_lo;

   always_comb begin
      lo_bit  = hi_bit - 3'd1;
      sub_hi  = REM_W'(d_in.den) << hi_bit;
      ge_hi   = d_in.rem >= sub_hi;
      rem_mid = ge_hi ? d_in.rem - sub_hi : d_in.rem;
      sub_lo  = REM_W'(d_in.den) << lo_bit;
      ge_lo   = rem_mid >= sub_lo;
      d_out_in.rem = ge_lo ? rem_mid - sub_lo : rem_mid;
      d_out_in.den = d_in.den;
      d_out_in.quo = {d_in.quo[Q_W-3:0], ge_hi, ge_lo};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_out_ff <= d_out_in;
      end
   end

endmodule

/* rtl/rgb_to_hsv_8bit.sv */
// Top level of the 8-bit RGB to HSV converter: pipeline control and the
// front stages; depends on rhsv_pkg and rhsv_divstage.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  request | req_valid, req_stall, req_red/green/blue | in
//  response| rsp_valid, rsp_stall, rsp_hue,           | out
//          | rsp_saturation, rsp_brightness           |
//
// Six register stages: max/min and hue numerator, scaled dividends and
// divisors, then four divider stages of two quotient bits each.
// One pixel per clock while the response is not stalled.
// Reset clears only the valid bits. A stall at the response freezes every
// stage while the output is valid, and request stall rises with it.
module rgb_to_hsv_8bit
   import rhsv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CHAN_W-1:0] req_red,
   input  logic [CHAN_W-1:0] req_green,
   input  logic [CHAN_W-1:0] req_blue,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CHAN_W-1:0] rsp_hue,
   output logic [CHAN_W-1:0] rsp_saturation,
   output logic [CHAN_W-1:0] rsp_brightness
);

   localparam int NSTG = 6;

   logic              advance;
   logic [NSTG-1:0]   vld_ff;
   logic [CHAN_W-1:0] bri_ff [NSTG];

   // stage 1
   logic [CHAN_W-1:0] mx_w, mn_w, dl_w;
   sect_type          sect_w;
   logic signed [11:0] num_s;
   logic [NUM_W-1:0]  num_in, num_ff;
   logic [CHAN_W-1:0] dl_ff;

   // stage 2
   div_type hdiv_in, hdiv_ff, sdiv_in, sdiv_ff;
   div_type hst [4];
   div_type sst [4];

   assign advance   = !rsp_stall || !vld_ff[NSTG-1];
   assign req_stall = !advance;

   always_comb begin
      mx_w = (req_red > req_green) ? req_red : req_green;
      mx_w = (mx_w > req_blue) ? mx_w : req_blue;
      mn_w = (req_red < req_green) ? req_red : req_green;
      mn_w = (mn_w < req_blue) ? mn_w : req_blue;
      dl_w = mx_w - mn_w;
      priority if (mx_w == req_red) begin
         sect_w = SECT_RED;
      end else if (mx_w == req_green) begin
         sect_w = SECT_GREEN;
      end else begin
         sect_w = SECT_BLUE;
      end
      unique case (sect_w)
         SECT_RED: begin
            num_s = $signed({4'd0, req_green}) - $signed({4'd0, req_blue});
            // wrap negative hue by one whole circle
            if (num_s < 0) begin
               num_s = num_s + $signed(12'(6 * dl_w));
            end
         end
         SECT_GREEN: begin
            num_s = $signed(12'(2 * dl_w)) + $signed({4'd0, req_blue})
                    - $signed({4'd0, req_red});
         end
         SECT_BLUE: begin
            num_s = $signed(12'(4 * dl_w)) + $signed({4'd0, req_red})
                    - $signed({4'd0, req_green});
         end
         default: begin
            num_s = '0;
         end
      endcase
      num_in = num_s[NUM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff    <= num_in;
         dl_ff     <= dl_w;
         bri_ff[0] <= mx_w;
      end
   end

   // Gray hue, black saturation: zero over a unit divisor gives zero.
   always_comb begin
      hdiv_in.rem = REM_W'(SCALE2) * REM_W'(num_ff) + REM_W'(6 * dl_ff);
      hdiv_in.den = (dl_ff == '0) ? DEN_W'(1) : DEN_W'(12 * dl_ff);
      hdiv_in.quo = '0;
      sdiv_in.rem = REM_W'(SCALE2) * REM_W'(dl_ff) + REM_W'(bri_ff[0]);
      sdiv_in.den = (bri_ff[0] == '0) ? DEN_W'(1) : DEN_W'({bri_ff[0], 1'b0});
      sdiv_in.quo = '0;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hdiv_ff   <= hdiv_in;
         sdiv_ff   <= sdiv_in;
         bri_ff[1] <= bri_ff[0];
      end
   end

   for (genvar k = 0; k < 4; k++) begin : g_div
      rhsv_divstage u_hue (
         .clock    (clock),
         .advance  (advance),
         .hi_bit   (3'(7 - 2 * k)),
         .d_in     ((k == 0) ? hdiv_ff : hst[(k == 0) ? 0 : k - 1]),
         .d_out_ff (hst[k])
      );
      rhsv_divstage u_sat (
         .clock    (clock),
         .advance  (advance),
         .hi_bit   (3'(7 - 2 * k)),
         .d_in     ((k == 0) ? sdiv_ff : sst[(k == 0) ? 0 : k - 1]),
         .d_out_ff (sst[k])
      );
      always_ff @(posedge clock) begin
         if (advance) begin
            bri_ff[k + 2] <= bri_ff[k + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_valid};
      end
   end

   assign rsp_valid      = vld_ff[NSTG-1];
   assign rsp_hue        = hst[3].quo;
   assign rsp_saturation = sst[3].quo;
   assign rsp_brightness = bri_ff[NSTG-1];

endmodule
